>>> rtl/core/vgts_pkg.sv
// vgts_pkg: shared types and constants of the voxel grid trilinear sampler
// no dependencies; used by the top, vgts_front and vgts_back in rtl/core
`default_nettype none

package vgts_pkg;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_DIM_X   = 2'd0,
    CFG_DIM_Y   = 2'd1,
    CFG_DIM_Z   = 2'd2,
    CFG_CHAN_EN = 2'd3
  } cfg_index_t;

  localparam int DIM_W = 9;
  localparam int EN_W = 5;
  localparam int OUT_CHANNELS = 9;
  localparam int POS_W = 24;
  localparam int T_W = 19;
  localparam int IDX_W = 29;

  // enable bit that gates each output channel
  localparam logic [2:0] CH_GROUP [OUT_CHANNELS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
  };

  typedef struct packed {
    logic               cmd;
    logic [3:0]         load_channel;
    logic [15:0]        load_address;
    logic signed [15:0] load_value;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] smoke_value;
    logic signed [15:0] fuel_value;
    logic signed [15:0] temperature_value;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] velocity_z;
    logic signed [15:0] texture_u;
    logic signed [15:0] texture_v;
    logic signed [15:0] texture_w;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim_x;
    logic [DIM_W-1:0] dim_y;
    logic [DIM_W-1:0] dim_z;
    logic [EN_W-1:0]  chan_en;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         load_channel;
    logic [15:0]        load_address;
    logic signed [15:0] load_value;
  } load_t;

  // one neighbour after classification: inside the grid, x and y + dim_y*z
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] x;
    logic [T_W-1:0]   t;
  } nb_t;

endpackage

`default_nettype wire

>>> rtl/core/voxel_grid_trilinear_sampler_top.sv
// voxel_grid_trilinear_sampler_top: config registers, front, middle queue,
// back and result queue; uses vgts_pkg, vgts_front, vgts_fifo, vgts_back
//
//   channel  ports                              beat when
//   input    in_push in_full in_item            in_push & !in_full
//   result   out_pop out_empty out_item         out_pop & !out_empty
//   config   cfg_we cfg_index cfg_data          cfg_we
//
// one beat per cycle in both directions while in_full and out_empty allow; a sample
// reaches the result side through two front stages, the middle queue, index
// multiply, ram read, weight multiply, sum. loads give no result beat.
// reset is synchronous and clears control only; voxel rams are not cleared.
// in_full rises on middle-queue credit, the back issues samples on result-queue
// credit, so either side stalls without losing a beat.
`default_nettype none

module voxel_grid_trilinear_sampler_top #(
  parameter int VOXEL_COUNT   = 65536,
  parameter int CHANNEL_COUNT = 9,
  parameter int FRACTION_BITS = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire vgts_pkg::in_item_t  in_item,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output vgts_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [8:0]          cfg_data
);

  localparam int MQ_DEPTH  = 4;
  localparam int OQ_DEPTH  = 8;
  localparam int WW        = 3 * FRACTION_BITS + 1;
  localparam int MID_W     = $bits(vgts_pkg::load_t) + 8 * $bits(vgts_pkg::nb_t) + 8 * WW;
  localparam int MC_W      = $clog2(MQ_DEPTH + 1);
  localparam int OC_W      = $clog2(OQ_DEPTH + 1);

  vgts_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x   <= vgts_pkg::DIM_W'(1);
      cfg_r.dim_y   <= vgts_pkg::DIM_W'(1);
      cfg_r.dim_z   <= vgts_pkg::DIM_W'(1);
      cfg_r.chan_en <= '0;
    end else if (cfg_we) begin
      case (vgts_pkg::cfg_index_t'(cfg_index))
        vgts_pkg::CFG_DIM_X:   cfg_r.dim_x   <= cfg_data;
        vgts_pkg::CFG_DIM_Y:   cfg_r.dim_y   <= cfg_data;
        vgts_pkg::CFG_DIM_Z:   cfg_r.dim_z   <= cfg_data;
        vgts_pkg::CFG_CHAN_EN: cfg_r.chan_en <= cfg_data[vgts_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

  logic                    in_accept;
  logic [1:0]              f_inflight;
  logic                    f_valid;
  vgts_pkg::load_t         f_load;
  vgts_pkg::nb_t [7:0]     f_nb;
  logic [7:0][WW-1:0]      f_w;
  logic [MID_W-1:0]        mid_wdata, mid_rdata;
  logic                    mid_empty, mid_pop;
  logic [MC_W-1:0]         mid_count;
  vgts_pkg::load_t         h_load;
  vgts_pkg::nb_t [7:0]     h_nb;
  logic [7:0][WW-1:0]      h_w;
  logic                    o_push, o_pop;
  vgts_pkg::out_item_t     o_item;
  logic [OC_W-1:0]         o_count;

  assign in_full   = (32'(mid_count) + 32'(f_inflight)) >= 32'(MQ_DEPTH);
  assign in_accept = in_push && !in_full;

  vgts_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_item),
    .cfg       (cfg_r),
    .inflight  (f_inflight),
    .mid_valid (f_valid),
    .mid_load  (f_load),
    .mid_nb    (f_nb),
    .mid_w     (f_w)
  );

  assign mid_wdata = {f_load, f_nb, f_w};

  vgts_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MQ_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (mid_wdata),
    .pop       (mid_pop),
    .pop_data  (mid_rdata),
    .empty     (mid_empty),
    .count     (mid_count)
  );

  assign {h_load, h_nb, h_w} = mid_rdata;

  vgts_back #(
    .VOXEL_COUNT   (VOXEL_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .FRACTION_BITS (FRACTION_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .OUT_DEPTH     (OQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_load  (h_load),
    .mid_nb    (h_nb),
    .mid_w     (h_w),
    .mid_pop   (mid_pop),
    .out_count (o_count),
    .out_push  (o_push),
    .out_item  (o_item)
  );

  assign o_pop = out_pop && !out_empty;

  vgts_fifo #(
    .WIDTH ($bits(vgts_pkg::out_item_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (o_push),
    .push_data (o_item),
    .pop       (o_pop),
    .pop_data  (out_item),
    .empty     (out_empty),
    .count     (o_count)
  );

  a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid |-> (32'(mid_count) < 32'(MQ_DEPTH) || mid_pop))
    else $error("middle queue overrun");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> (32'(o_count) < 32'(OQ_DEPTH) || o_pop))
    else $error("result queue overrun");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result beat dropped");

endmodule

`default_nettype wire

>>> rtl/core/vgts_ram.sv
// vgts_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module vgts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/vgts_fifo.sv
// vgts_fifo: small register queue with occupancy count, depth a power of two
// no dependencies; callers keep push within free space by credit
`default_nettype none

module vgts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           pop_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rp_r];
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;

endmodule

`default_nettype wire

>>> rtl/core/vgts_front.sv
// vgts_front: takes input beats, floors positions, classifies the eight
// neighbours and forms their weights; two register stages; uses vgts_pkg
`default_nettype none

module vgts_front #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire vgts_pkg::in_item_t            item,
  input  wire vgts_pkg::cfg_t                cfg,
  output logic      [1:0]                    inflight,
  output logic                               mid_valid,
  output vgts_pkg::load_t                    mid_load,
  output vgts_pkg::nb_t [7:0]                mid_nb,
  output logic      [7:0][3*FRACTION_BITS:0] mid_w
);

  localparam int F   = FRACTION_BITS;
  localparam int WA  = F + 1;
  localparam int WXY = 2 * F + 1;
  localparam int WW  = 3 * F + 1;
  localparam int WWX = 3 * F + 2;
  localparam int DW  = vgts_pkg::DIM_W;
  localparam int TW  = vgts_pkg::T_W;
  localparam logic [WA-1:0] W_ONE = WA'(1) << F;

  logic                va_r;
  vgts_pkg::in_item_t  item_a_r;
  logic                vb_r;
  vgts_pkg::load_t     load_b_r;
  logic                ok_b_r  [8];
  logic [DW-1:0]       x_b_r   [8];
  logic [DW-1:0]       y_b_r   [8];
  logic [DW-1:0]       z_b_r   [8];
  logic [WXY-1:0]      wxy_b_r [8];
  logic [WA-1:0]       wz_b_r  [8];

  logic signed [23:0]  pos [3];
  logic [DW-1:0]       dim [3];
  logic                ok_ax [3][2];
  logic [DW-1:0]       co_ax [3][2];
  logic [WA-1:0]       w_ax  [3][2];

  assign pos[0] = item_a_r.pos_x;
  assign pos[1] = item_a_r.pos_y;
  assign pos[2] = item_a_r.pos_z;
  assign dim[0] = cfg.dim_x;
  assign dim[1] = cfg.dim_y;
  assign dim[2] = cfg.dim_z;

  always_comb begin
    logic signed [23:0] corner;
    logic signed [24:0] c;
    logic [F-1:0]       frac;
    for (int a = 0; a < 3; a++) begin
      corner = pos[a] >>> F;
      frac   = pos[a][F-1:0];
      for (int d = 0; d < 2; d++) begin
        c           = {corner[23], corner} + 25'(d);
        ok_ax[a][d] = !c[24] && (c[23:0] < {15'b0, dim[a]});
        co_ax[a][d] = c[DW-1:0];
      end
      w_ax[a][0] = W_ONE - {1'b0, frac};
      w_ax[a][1] = {1'b0, frac};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [2*WA-1:0] wxy;
    if (accept) begin
      item_a_r <= item;
    end
    load_b_r.cmd          <= item_a_r.cmd;
    load_b_r.load_channel <= item_a_r.load_channel;
    load_b_r.load_address <= item_a_r.load_address;
    load_b_r.load_value   <= item_a_r.load_value;
    for (int n = 0; n < 8; n++) begin
      wxy        = w_ax[0][n & 1] * w_ax[1][(n >> 1) & 1];
      ok_b_r[n]  <= ok_ax[0][n & 1] && ok_ax[1][(n >> 1) & 1] && ok_ax[2][(n >> 2) & 1];
      x_b_r[n]   <= co_ax[0][n & 1];
      y_b_r[n]   <= co_ax[1][(n >> 1) & 1];
      z_b_r[n]   <= co_ax[2][(n >> 2) & 1];
      wxy_b_r[n] <= wxy[WXY-1:0];
      wz_b_r[n]  <= w_ax[2][(n >> 2) & 1];
    end
  end

  always_comb begin
    logic [WWX-1:0] wfull;
    for (int n = 0; n < 8; n++) begin
      wfull        = WWX'(wxy_b_r[n]) * WWX'(wz_b_r[n]);
      mid_w[n]     = wfull[WW-1:0];
      mid_nb[n].ok = ok_b_r[n];
      mid_nb[n].x  = x_b_r[n];
      mid_nb[n].t  = TW'(y_b_r[n]) + TW'(cfg.dim_y) * TW'(z_b_r[n]);
    end
  end

  assign mid_valid = vb_r;
  assign mid_load  = load_b_r;
  assign inflight  = {1'b0, va_r} + {1'b0, vb_r};

endmodule

`default_nettype wire

>>> rtl/core/vgts_back.sv
// vgts_back: issues loads and gathers to the replicated voxel rams, weights,
// sums, rounds and saturates; uses vgts_pkg and vgts_ram
`default_nettype none

module vgts_back #(
  parameter int VOXEL_COUNT   = 65536,
  parameter int CHANNEL_COUNT = 9,
  parameter int FRACTION_BITS = 8,
  parameter int SAMPLE_BITS   = 16,
  parameter int OUT_DEPTH     = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire vgts_pkg::cfg_t                      cfg,
  input  wire logic                                mid_empty,
  input  wire vgts_pkg::load_t                     mid_load,
  input  wire vgts_pkg::nb_t [7:0]                 mid_nb,
  input  wire logic      [7:0][3*FRACTION_BITS:0]  mid_w,
  output logic                                     mid_pop,
  input  wire logic      [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                                     out_push,
  output vgts_pkg::out_item_t                      out_item
);

  localparam int F   = FRACTION_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int WW  = 3 * F + 1;
  localparam int PW  = WW + SB + 1;
  localparam int AW_ = PW + 3;
  localparam int RW  = AW_ + 1;
  localparam int AW  = $clog2(VOXEL_COUNT);
  localparam int NC  = vgts_pkg::OUT_CHANNELS;
  localparam int IW  = vgts_pkg::IDX_W;
  localparam logic [RW-1:0] HALF = RW'(1) << (3 * F - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic                   c_v_r, c_s_r, d_v_r, e_v_r, f_v_r;
  vgts_pkg::load_t        c_load_r;
  logic [AW-1:0]          c_addr_r [8];
  logic                   c_ok_r   [8];
  logic [WW-1:0]          c_w_r    [8];
  logic                   d_ok_r   [8];
  logic [WW-1:0]          d_w_r    [8];
  logic signed [PW-1:0]   prod_r   [NC][8];
  logic signed [AW_-1:0]  acc_r    [NC];
  logic [SB-1:0]          rd       [NC][8];
  logic signed [15:0]     vals     [NC];

  logic [3:0] inflight;
  logic       wr_ok;
  logic [31:0] lv32;

  assign inflight = 4'(c_s_r) + 4'(d_v_r) + 4'(e_v_r) + 4'(f_v_r);
  assign mid_pop  = !mid_empty && (mid_load.cmd == vgts_pkg::CMD_LOAD ||
                    (32'(out_count) + 32'(inflight)) < 32'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      c_s_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      c_v_r <= mid_pop;
      c_s_r <= mid_pop && mid_load.cmd == vgts_pkg::CMD_SAMPLE;
      d_v_r <= c_s_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [IW-1:0] idx;
    logic [31:0]   idx32;
    c_load_r <= mid_load;
    for (int n = 0; n < 8; n++) begin
      idx         = IW'(mid_nb[n].x) + IW'(cfg.dim_x) * IW'(mid_nb[n].t);
      idx32       = 32'(idx);
      c_addr_r[n] <= idx32[AW-1:0];
      c_ok_r[n]   <= mid_nb[n].ok && idx32 < 32'(VOXEL_COUNT);
      c_w_r[n]    <= mid_w[n];
      d_ok_r[n]   <= c_ok_r[n];
      d_w_r[n]    <= c_w_r[n];
    end
  end

  assign wr_ok = c_v_r && c_load_r.cmd == vgts_pkg::CMD_LOAD &&
                 32'(c_load_r.load_channel) < 32'(CHANNEL_COUNT) &&
                 32'(c_load_r.load_address) < 32'(VOXEL_COUNT);
  assign lv32  = 32'(c_load_r.load_value);

  for (genvar ch = 0; ch < NC; ch++) begin : g_ch
    if (ch < CHANNEL_COUNT) begin : g_on
      logic          we;
      logic [31:0]   wa32;
      assign we   = wr_ok && c_load_r.load_channel == 4'(ch);
      assign wa32 = 32'(c_load_r.load_address);
      for (genvar n = 0; n < 8; n++) begin : g_nb
        vgts_ram #(
          .WIDTH (SB),
          .DEPTH (VOXEL_COUNT)
        ) u_ram (
          .clk   (clk),
          .we    (we),
          .waddr (wa32[AW-1:0]),
          .wdata (lv32[SB-1:0]),
          .raddr (c_addr_r[n]),
          .rdata (rd[ch][n])
        );
      end
    end else begin : g_off
      for (genvar n = 0; n < 8; n++) begin : g_nb
        assign rd[ch][n] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [PW-1:0]  wa, sa;
    logic signed [AW_-1:0] sum;
    for (int ch = 0; ch < NC; ch++) begin
      for (int n = 0; n < 8; n++) begin
        wa = PW'($signed({1'b0, d_w_r[n]}));
        sa = PW'($signed(rd[ch][n]));
        prod_r[ch][n] <= d_ok_r[n] ? wa * sa : '0;
      end
      sum = '0;
      for (int n = 0; n < 8; n++) begin
        sum = sum + AW_'(prod_r[ch][n]);
      end
      acc_r[ch] <= sum;
    end
  end

  always_comb begin
    logic signed [RW-1:0] r, q;
    for (int ch = 0; ch < NC; ch++) begin
      r = RW'(acc_r[ch]) + $signed(HALF);
      q = r >>> (3 * F);
      if (q > SAT_HI) begin
        q = SAT_HI;
      end else if (q < SAT_LO) begin
        q = SAT_LO;
      end
      if (ch < CHANNEL_COUNT && cfg.chan_en[vgts_pkg::CH_GROUP[ch]]) begin
        vals[ch] = q[15:0];
      end else begin
        vals[ch] = '0;
      end
    end
  end

  assign out_push                   = f_v_r;
  assign out_item.smoke_value       = vals[0];
  assign out_item.fuel_value        = vals[1];
  assign out_item.temperature_value = vals[2];
  assign out_item.velocity_x        = vals[3];
  assign out_item.velocity_y        = vals[4];
  assign out_item.velocity_z        = vals[5];
  assign out_item.texture_u         = vals[6];
  assign out_item.texture_v         = vals[7];
  assign out_item.texture_w         = vals[8];

endmodule

`default_nettype wire
